// ===== sv/sensor_frame_odometry_parser_assert.svh =====
// Assertion macros shared by the sensor frame odometry parser RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SENSOR_FRAME_ODOMETRY_PARSER_ASSERT_SVH
`define SENSOR_FRAME_ODOMETRY_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFOP_ASSERT_IMP(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sfop assertion failed");
`define SFOP_ASSERT_NXT(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sfop assertion failed");
`else
`define SFOP_ASSERT_IMP(name, clk, rst_n, a, c)
`define SFOP_ASSERT_NXT(name, clk, rst_n, a, c)
`endif
`endif

// ===== sv/sfop_pkg.sv =====
// Package for the sensor frame odometry parser: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package sfop_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  HEADER_RESET = 8'd19;
  localparam logic [15:0] THRESH_RESET = 16'd100;

  // byte index at which both encoder counts are in the store
  localparam int WHEEL_IDX = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER = 2'd0,
    REG_THRESH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  header;
    logic [15:0] left_count;
    logic [15:0] right_count;
    logic [7:0]  bump;
    logic [31:0] cliff;
    logic [47:0] lights_l;
    logic [47:0] lights_r;
    logic [15:0] batt;
  } frame_t;

  typedef struct packed {
    logic last;
    logic sum_zero;
    logic pre_en;
  } cap_ctl_t;

endpackage

// ===== sv/sensor_frame_odometry_parser.sv =====
// Top level of the sensor frame odometry parser: config, handshake, result register.
// Depends on sfop_pkg, sfop_capture, sfop_wheel and the assertion header.
`timescale 1ns / 1ps
`include "sensor_frame_odometry_parser_assert.svh"
// Takes one frame byte per cycle on the in_ channel, with in_frame_begin restarting
// a frame. After the last of FRAME_BYTES bytes the frame is checked and one result
// word appears on out_ in the next cycle; bad frames carry only a status code. The
// only stall is on a frame's last byte while the previous result is still waiting.
// header_value (index 0) and rollover_threshold (index 1) are written on cfg_.
module sensor_frame_odometry_parser #(
  parameter int FRAME_BYTES = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_frame_begin,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic signed [31:0]              out_dist_left,
  output logic signed [31:0]              out_dist_right,
  output logic signed [31:0]              out_total_left,
  output logic signed [31:0]              out_total_right,
  output logic [7:0]                      out_bumper_bits,
  output logic [31:0]                     out_cliff_bytes,
  output logic [47:0]                     out_lights_left_group,
  output logic [47:0]                     out_lights_right_group,
  output logic [15:0]                     out_battery_voltage,
  output logic [15:0]                     out_left_raw_count,
  output logic [15:0]                     out_right_raw_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfop_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]          header_r;
  logic [15:0]         thresh_r;
  logic                acc, fin, good;
  sfop_pkg::cap_ctl_t  ctl;
  sfop_pkg::frame_t    frame;
  sfop_pkg::status_t   status;
  logic signed [31:0]  total_l, total_r_w, dist_l, dist_r_w;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          status_r;
  logic signed [31:0]  dist_l_r, dist_r_r, total_l_r, total_r_r;
  logic [7:0]          bump_r;
  logic [31:0]         cliff_r;
  logic [47:0]         lights_l_r, lights_r_r;
  logic [15:0]         batt_r, lcnt_r, rcnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= sfop_pkg::HEADER_RESET;
      thresh_r <= sfop_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      case (sfop_pkg::cfg_reg_t'(cfg_index))
        sfop_pkg::REG_HEADER: header_r <= cfg_data[7:0];
        sfop_pkg::REG_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !ctl.last || !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign fin      = acc && ctl.last;

  sfop_capture #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .rx_byte     (in_rx_byte),
    .frame_begin (in_frame_begin),
    .ctl         (ctl),
    .frame       (frame)
  );

  always_comb begin
    if (frame.header != header_r) begin
      status = sfop_pkg::ST_BAD_HDR;
    end else if (!ctl.sum_zero) begin
      status = sfop_pkg::ST_BAD_SUM;
    end else begin
      status = sfop_pkg::ST_OK;
    end
    good = fin && (status == sfop_pkg::ST_OK);
  end

  sfop_wheel u_wheel_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .pre_en    (ctl.pre_en),
    .upd_en    (good),
    .count     (frame.left_count),
    .threshold (thresh_r),
    .total_nxt (total_l),
    .dist_nxt  (dist_l)
  );

  sfop_wheel u_wheel_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .pre_en    (ctl.pre_en),
    .upd_en    (good),
    .count     (frame.right_count),
    .threshold (thresh_r),
    .total_nxt (total_r_w),
    .dist_nxt  (dist_r_w)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status_r <= status;
      if (status == sfop_pkg::ST_OK) begin
        dist_l_r   <= dist_l;
        dist_r_r   <= dist_r_w;
        total_l_r  <= total_l;
        total_r_r  <= total_r_w;
        bump_r     <= frame.bump;
        cliff_r    <= frame.cliff;
        lights_l_r <= frame.lights_l;
        lights_r_r <= frame.lights_r;
        batt_r     <= frame.batt;
        lcnt_r     <= frame.left_count;
        rcnt_r     <= frame.right_count;
      end else begin
        dist_l_r   <= 32'sd0;
        dist_r_r   <= 32'sd0;
        total_l_r  <= 32'sd0;
        total_r_r  <= 32'sd0;
        bump_r     <= 8'd0;
        cliff_r    <= 32'd0;
        lights_l_r <= 48'd0;
        lights_r_r <= 48'd0;
        batt_r     <= 16'd0;
        lcnt_r     <= 16'd0;
        rcnt_r     <= 16'd0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_dist_left          = dist_l_r;
  assign out_dist_right         = dist_r_r;
  assign out_total_left         = total_l_r;
  assign out_total_right        = total_r_r;
  assign out_bumper_bits        = bump_r;
  assign out_cliff_bytes        = cliff_r;
  assign out_lights_left_group  = lights_l_r;
  assign out_lights_right_group = lights_r_r;
  assign out_battery_voltage    = batt_r;
  assign out_left_raw_count     = lcnt_r;
  assign out_right_raw_count    = rcnt_r;

  `SFOP_ASSERT_NXT(a_fin_valid, clk, rst_n, fin, out_valid_r)
  `SFOP_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid_r && (status_r != sfop_pkg::ST_OK), (total_l_r == 32'sd0) && (dist_r_r == 32'sd0))
  `SFOP_ASSERT_NXT(a_good_total, clk, rst_n, good, total_l_r == $past(total_l))

endmodule

// ===== sv/sfop_capture.sv =====
// Frame capture: byte index, modulo-256 running sum and frame byte registers.
// Depends on sfop_pkg and sensor_frame_odometry_parser_assert.svh.
`timescale 1ns / 1ps
`include "sensor_frame_odometry_parser_assert.svh"
module sfop_capture #(
  parameter int FRAME_BYTES = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        rx_byte,
  input  logic              frame_begin,
  output sfop_pkg::cap_ctl_t ctl,
  output sfop_pkg::frame_t  frame
);

  localparam int IW = $clog2(FRAME_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_BYTES - 1);

  logic [IW-1:0] idx_r, idx_nxt, idx_eff;
  logic [7:0]    sum_r, sum_nxt, sum_eff;
  logic [7:0]    frame_r [FRAME_BYTES];

  assign idx_eff = frame_begin ? '0 : idx_r;
  assign sum_eff = frame_begin ? 8'd0 : sum_r;
  assign sum_nxt = sum_eff + rx_byte;

  always_comb begin
    ctl.last     = (idx_eff == LAST_IDX);
    ctl.sum_zero = (sum_nxt == 8'd0);
    ctl.pre_en   = acc && (idx_eff == IW'(sfop_pkg::WHEEL_IDX));
    idx_nxt      = ctl.last ? '0 : idx_eff + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= 8'd0;
    end else if (acc) begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      frame_r[idx_eff] <= rx_byte;
    end
  end

  always_comb begin
    frame.header      = frame_r[0];
    frame.left_count  = {frame_r[3], frame_r[4]};
    frame.right_count = {frame_r[6], frame_r[7]};
    frame.bump        = frame_r[9];
    frame.cliff       = {frame_r[11], frame_r[13], frame_r[15], frame_r[17]};
    frame.lights_l    = {frame_r[19], frame_r[20], frame_r[22], frame_r[23],
                         frame_r[25], frame_r[26]};
    frame.lights_r    = {frame_r[28], frame_r[29], frame_r[31], frame_r[32],
                         frame_r[34], frame_r[35]};
    frame.batt        = {frame_r[37], frame_r[38]};
  end

  `SFOP_ASSERT_IMP(a_idx_range, clk, rst_n, 1'b1, idx_r <= LAST_IDX)
  `SFOP_ASSERT_NXT(a_last_wraps, clk, rst_n, acc && ctl.last, idx_r == '0)
  `SFOP_ASSERT_NXT(a_sum_track, clk, rst_n, acc, sum_r == $past(sum_nxt))

endmodule

// ===== sv/sfop_wheel.sv =====
// One wheel's odometry: delta with rollover hold, wrapping total and distance.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps
module sfop_wheel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pre_en,
  input  logic               upd_en,
  input  logic [15:0]        count,
  input  logic [15:0]        threshold,
  output logic signed [31:0] total_nxt,
  output logic signed [31:0] dist_nxt
);

  logic [15:0]        prev_r;
  logic signed [16:0] delta_r, delta_nxt;
  logic signed [31:0] total_r, dist_r;
  logic signed [16:0] diff_r, diff_nxt, thr_neg;
  logic               nz_r;
  logic               rolled;
  logic signed [31:0] delta_ext;

  assign diff_nxt = $signed({1'b0, count}) - $signed({1'b0, prev_r});

  always_ff @(posedge clk) begin
    if (pre_en) begin
      diff_r <= diff_nxt;
      nz_r   <= (prev_r != 16'd0);
    end
  end

  always_comb begin
    thr_neg   = $signed(17'd0 - {1'b0, threshold});
    rolled    = (diff_r < thr_neg);
    delta_nxt = (!rolled && nz_r) ? diff_r : delta_r;
    delta_ext = 32'(delta_nxt);
    total_nxt = total_r + delta_ext;
    dist_nxt  = (delta_nxt == 17'sd0) ? 32'sd0 : dist_r + delta_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 16'd0;
      delta_r <= 17'sd0;
      total_r <= 32'sd0;
      dist_r  <= 32'sd0;
    end else if (upd_en) begin
      prev_r  <= count;
      delta_r <= delta_nxt;
      total_r <= total_nxt;
      dist_r  <= dist_nxt;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for sensor_frame_odometry_parser: byte frames in, one report word out.
// Predicts each report from its own frame and wheel tracking; depends on sfop_pkg and the RTL.
`timescale 1ns / 1ps
module tb;

  localparam int FRAME_BYTES = 40;
  localparam int LAT_PAD     = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam sfop_pkg::cfg_reg_t REG_SPARE = sfop_pkg::cfg_reg_t'(2'd3);

  typedef logic [7:0] frame_buf_t [0:FRAME_BYTES-1];
  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    sfop_pkg::status_t status;
    logic [31:0] dist_l;
    logic [31:0] dist_r;
    logic [31:0] total_l;
    logic [31:0] total_r;
    logic [7:0]  bump;
    logic [31:0] cliff;
    logic [47:0] lights_l;
    logic [47:0] lights_r;
    logic [15:0] batt;
    logic [15:0] raw_l;
    logic [15:0] raw_r;
  } odo_report_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_frame_begin;
  logic [7:0] in_rx_byte;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic signed [31:0] out_dist_left, out_dist_right, out_total_left, out_total_right;
  logic [7:0]  out_bumper_bits;
  logic [31:0] out_cliff_bytes;
  logic [47:0] out_lights_left_group, out_lights_right_group;
  logic [15:0] out_battery_voltage, out_left_raw_count, out_right_raw_count;
  logic cfg_valid, cfg_ready;
  logic [sfop_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfop_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [7:0]         hdr_reg;
  logic [15:0]        thr_reg;
  int                 frame_pos;
  logic [7:0]         frame_sum;
  logic [7:0]         frame_mem [0:FRAME_BYTES-1];
  logic [15:0]        prev_l, prev_r;
  logic signed [16:0] delta_l, delta_r;
  logic [31:0]        total_l, total_r, dist_l, dist_r;
  odo_report_t        pending_reports [$];

  // stimulus-side encoder positions
  logic [15:0] enc_l, enc_r;

  logic snd_idle_en, rcv_idle_en;
  int   hold_req;
  int   mismatches;

  sensor_frame_odometry_parser #(.FRAME_BYTES(FRAME_BYTES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .in_frame_begin(in_frame_begin),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status),
    .out_dist_left(out_dist_left), .out_dist_right(out_dist_right),
    .out_total_left(out_total_left), .out_total_right(out_total_right),
    .out_bumper_bits(out_bumper_bits), .out_cliff_bytes(out_cliff_bytes),
    .out_lights_left_group(out_lights_left_group),
    .out_lights_right_group(out_lights_right_group),
    .out_battery_voltage(out_battery_voltage),
    .out_left_raw_count(out_left_raw_count), .out_right_raw_count(out_right_raw_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sensor_frame_odometry_parser test failed");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [15:0] be16(int p);
    return {frame_mem[p], frame_mem[p+1]};
  endfunction

  function automatic void wheel_step(input logic [15:0] now, inout logic [15:0] prev,
                                     inout logic signed [16:0] delta,
                                     inout logic [31:0] total, inout logic [31:0] trip);
    int diff;
    diff = int'(now) - int'(prev);
    if (!(diff < -int'(thr_reg)) && prev != 16'd0)
      delta = diff[16:0];
    prev = now;
    total = total + {{15{delta[16]}}, delta};
    trip  = trip + {{15{delta[16]}}, delta};
    if (delta == 17'sd0)
      trip = 32'd0;
  endfunction

  task automatic track_byte(logic [7:0] b, logic fb);
    odo_report_t r;
    logic [15:0] lc, rc;
    if (fb) begin
      frame_pos = 0;
      frame_sum = 8'd0;
    end
    frame_mem[frame_pos] = b;
    frame_sum = frame_sum + b;
    if (frame_pos < FRAME_BYTES - 1) begin
      frame_pos++;
      return;
    end
    frame_pos = 0;
    r = '0;
    if (frame_mem[0] != hdr_reg) begin
      r.status = sfop_pkg::ST_BAD_HDR;
    end else if (frame_sum != 8'd0) begin
      r.status = sfop_pkg::ST_BAD_SUM;
    end else begin
      lc = be16(3);
      rc = be16(6);
      wheel_step(lc, prev_l, delta_l, total_l, dist_l);
      wheel_step(rc, prev_r, delta_r, total_r, dist_r);
      r.status   = sfop_pkg::ST_OK;
      r.dist_l   = dist_l;
      r.dist_r   = dist_r;
      r.total_l  = total_l;
      r.total_r  = total_r;
      r.bump     = frame_mem[9];
      r.cliff    = {frame_mem[11], frame_mem[13], frame_mem[15], frame_mem[17]};
      r.lights_l = {be16(19), be16(22), be16(25)};
      r.lights_r = {be16(28), be16(31), be16(34)};
      r.batt     = be16(37);
      r.raw_l    = lc;
      r.raw_r    = rc;
    end
    pending_reports.push_back(r);
  endtask

  // ---------------- report checker ----------------
  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    odo_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report word with none expected");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, out_status);
        check_field("dist_left", want.dist_l, $unsigned(out_dist_left));
        check_field("dist_right", want.dist_r, $unsigned(out_dist_right));
        check_field("total_left", want.total_l, $unsigned(out_total_left));
        check_field("total_right", want.total_r, $unsigned(out_total_right));
        check_field("bumper_bits", want.bump, out_bumper_bits);
        check_field("cliff_bytes", want.cliff, out_cliff_bytes);
        check_field("lights_left_group", want.lights_l, out_lights_left_group);
        check_field("lights_right_group", want.lights_r, out_lights_right_group);
        check_field("battery_voltage", want.batt, out_battery_voltage);
        check_field("left_raw_count", want.raw_l, out_left_raw_count);
        check_field("right_raw_count", want.raw_r, out_right_raw_count);
      end
    end
  end

  // ---------------- receiver ----------------
  initial begin : report_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rcv_idle_en || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // ---------------- sender and config ----------------
  task automatic send_byte(logic [7:0] b, logic fb);
    if (snd_idle_en) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_begin <= fb;
    do @(posedge clk); while (!in_ready);
    track_byte(b, fb);
  endtask

  task automatic send_frame(frame_buf_t f, logic mark);
    for (int i = 0; i < FRAME_BYTES; i++)
      send_byte(f[i], (i == 0) ? mark : 1'b0);
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), $urandom_range(0, 9) == 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_reg(sfop_pkg::cfg_reg_t idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfop_pkg::REG_HEADER: hdr_reg = d[7:0];
      sfop_pkg::REG_THRESH: thr_reg = d;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] hdr_word, logic [15:0] thr_word);
    settle();
    write_reg(sfop_pkg::REG_HEADER, hdr_word);
    write_reg(REG_SPARE, 16'($urandom));
    write_reg(sfop_pkg::REG_THRESH, thr_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic frame_buf_t make_frame(logic [7:0] hdr, logic [15:0] lc, logic [15:0] rc,
                                            fill_t fill);
    frame_buf_t f;
    logic [7:0] s;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      case (fill)
        FILL_ZERO: f[i] = 8'h00;
        FILL_ONES: f[i] = 8'hFF;
        default:   f[i] = 8'($urandom);
      endcase
    end
    f[0] = hdr;
    {f[3], f[4]} = lc;
    {f[6], f[7]} = rc;
    s = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++)
      s = s + f[i];
    f[FRAME_BYTES-1] = 8'd0 - s;
    return f;
  endfunction

  function automatic frame_buf_t break_sum(frame_buf_t f);
    int k;
    k = $urandom_range(1, FRAME_BYTES - 1);
    f[k] = f[k] + 8'($urandom_range(1, 255));
    return f;
  endfunction

  function automatic logic [15:0] next_count(logic [15:0] cur);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return cur;
    if (pick < 22) return cur - 16'($urandom_range(0, 300));
    if (pick < 28) return 16'($urandom);
    if (pick < 31) return 16'd0;
    return cur + 16'($urandom_range(1, 400));
  endfunction

  task automatic send_good(logic mark, fill_t fill);
    enc_l = next_count(enc_l);
    enc_r = next_count(enc_r);
    send_frame(make_frame(hdr_reg, enc_l, enc_r, fill), mark);
  endtask

  // ---------------- tests ----------------
  task automatic test_wheel_cases();
    send_frame(make_frame(hdr_reg, 16'h0000, 16'hFFFF, FILL_ZERO), 1'b1);
    send_frame(make_frame(hdr_reg, 16'h0010, 16'hFFF0, FILL_ONES), 1'b0);
    send_frame(make_frame(hdr_reg, 16'h0200, 16'hFFF0, FILL_RAND), 1'b0);
    // drop equal to threshold is a real move, one more is rollover
    send_frame(make_frame(hdr_reg, 16'h019C, 16'h0005, FILL_RAND), 1'b1);
    send_frame(make_frame(hdr_reg, 16'h0137, 16'h0010, FILL_RAND), 1'b0);
    send_frame(make_frame(hdr_reg, 16'h0137, 16'h0010, FILL_RAND), 1'b0);
  endtask

  task automatic test_rejects();
    frame_buf_t f;
    f = make_frame(hdr_reg ^ 8'h80, 16'h1234, 16'h4321, FILL_RAND);
    f[FRAME_BYTES-1] = f[FRAME_BYTES-1] - 8'h80;
    send_frame(f, 1'b1);
    send_frame(break_sum(make_frame(hdr_reg ^ 8'h01, 16'h1234, 16'h4321, FILL_ONES)), 1'b0);
    send_frame(break_sum(make_frame(hdr_reg, 16'h1234, 16'h4321, FILL_RAND)), 1'b0);
    send_frame(make_frame(hdr_reg, 16'h0140, 16'h0020, FILL_RAND), 1'b0);
  endtask

  task automatic test_restart();
    send_noise(15);
    send_frame(make_frame(hdr_reg, 16'h0150, 16'h0030, FILL_RAND), 1'b1);
    send_frame(make_frame(hdr_reg, 16'h0150, 16'h0031, FILL_RAND), 1'b0);
    send_noise(27);
    send_frame(make_frame(hdr_reg, 16'h0160, 16'h0031, FILL_RAND), 1'b1);
    enc_l = 16'h0160;
    enc_r = 16'h0031;
  endtask

  task automatic test_config_extremes();
    set_config(16'hFF00, 16'h0000);
    send_frame(make_frame(8'h00, 16'h0170, 16'h0040, FILL_RAND), 1'b1);
    send_frame(make_frame(8'h00, 16'h016F, 16'h0040, FILL_RAND), 1'b0);
    send_frame(make_frame(sfop_pkg::HEADER_RESET, 16'h0100, 16'h0100, FILL_RAND), 1'b0);
    set_config(16'h00FF, 16'hFFFF);
    send_frame(make_frame(8'hFF, 16'hFFFF, 16'hFFFF, FILL_ONES), 1'b1);
    send_frame(make_frame(8'hFF, 16'h0001, 16'h0000, FILL_RAND), 1'b0);
    send_frame(make_frame(8'hFF, 16'h0002, 16'h0005, FILL_RAND), 1'b0);
    set_config({8'h5A, sfop_pkg::HEADER_RESET}, sfop_pkg::THRESH_RESET);
    enc_l = 16'h0002;
    enc_r = 16'h0005;
  endtask

  task automatic test_backpressure();
    snd_idle_en <= 1'b0;
    hold_req    <= hold_req + 1;
    repeat (3) send_good(1'b1, FILL_RAND);
    settle();
    snd_idle_en <= 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [15:0] hdr_word, thr_word;
    int pick;
    for (int phase = 0; phase < 3; phase++) begin
      hdr_word = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) hdr_word[7:0] = 8'h00;
      if (pick == 1) hdr_word[7:0] = 8'hFF;
      pick = $urandom_range(0, 9);
      if (pick < 2)      thr_word = 16'h0000;
      else if (pick < 3) thr_word = 16'hFFFF;
      else if (pick < 8) thr_word = 16'($urandom_range(0, 400));
      else               thr_word = 16'($urandom);
      set_config(hdr_word, thr_word);
      snd_idle_en <= (phase != 2);
      rcv_idle_en <= (phase != 2);
      for (int n = 0; n < 2; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 74) begin
          send_good((frame_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1)), FILL_RAND);
        end else if (pick < 82) begin
          send_frame(make_frame(hdr_reg ^ 8'($urandom_range(1, 255)), 16'($urandom),
                                16'($urandom), FILL_RAND), 1'b1);
        end else if (pick < 90) begin
          send_frame(break_sum(make_frame(hdr_reg, 16'($urandom), 16'($urandom),
                                          FILL_RAND)), 1'b1);
        end else begin
          send_noise($urandom_range(1, 60));
        end
      end
      if (frame_pos != 0)
        send_good(1'b1, FILL_RAND);
    end
    snd_idle_en <= 1'b1;
    rcv_idle_en <= 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    in_frame_begin = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = sfop_pkg::REG_HEADER;
    cfg_data       = '0;
    snd_idle_en    = 1'b1;
    rcv_idle_en    = 1'b1;
    hold_req       = 0;
    mismatches     = 0;
    hdr_reg        = sfop_pkg::HEADER_RESET;
    thr_reg        = sfop_pkg::THRESH_RESET;
    frame_pos      = 0;
    frame_sum      = 8'd0;
    prev_l = 16'd0;  prev_r = 16'd0;
    delta_l = 17'sd0; delta_r = 17'sd0;
    total_l = 32'd0; total_r = 32'd0;
    dist_l = 32'd0;  dist_r = 32'd0;
    enc_l = 16'd0;   enc_r = 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_wheel_cases();
    test_rejects();
    test_restart();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("sensor_frame_odometry_parser test passed");
    else
      $display("sensor_frame_odometry_parser test failed");
    $finish;
  end

endmodule
